// ----- rtl/core/cmv_pkg.sv -----
// Shared types, phase codes and constants for the CoAP message validator.
// Used by every module under rtl/core except cmv_queue; depends on nothing else.
package cmv_pkg;

    localparam int DEFAULT_MAX_MESSAGE_BYTES = 2048;
    localparam int IN_QUEUE_LOG2 = 2;
    localparam int OUT_QUEUE_LOG2 = 1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_OPTION = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD = 1'd1;
    localparam logic [15:0] MAX_OPTION_RESET = 16'd1034;
    localparam logic [10:0] MAX_PAYLOAD_RESET = 11'd1024;

    localparam int PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PH_HDR0 = 4'd0;
    localparam logic [PHASE_W-1:0] PH_HDR1 = 4'd1;
    localparam logic [PHASE_W-1:0] PH_HDR2 = 4'd2;
    localparam logic [PHASE_W-1:0] PH_HDR3 = 4'd3;
    localparam logic [PHASE_W-1:0] PH_TOKEN = 4'd4;
    localparam logic [PHASE_W-1:0] PH_OPT_FIRST = 4'd5;
    localparam logic [PHASE_W-1:0] PH_OPT_START = 4'd6;
    localparam logic [PHASE_W-1:0] PH_DELTA_EXT = 4'd7;
    localparam logic [PHASE_W-1:0] PH_LEN_EXT = 4'd8;
    localparam logic [PHASE_W-1:0] PH_VALUE = 4'd9;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 4'd10;
    localparam logic [PHASE_W-1:0] PH_SKIP = 4'd11;

    localparam logic [1:0] ERR_OK = 2'd0;
    localparam logic [1:0] ERR_FORMAT = 2'd1;
    localparam logic [1:0] ERR_VERSION = 2'd2;
    localparam logic [1:0] ERR_PAYLOAD = 2'd3;

    localparam logic [1:0] VERSION_ONE = 2'h1;
    localparam logic [7:0] MARKER_BYTE = 8'hFF;
    localparam logic [3:0] NIB_EXT1 = 4'd13;
    localparam logic [3:0] NIB_EXT2 = 4'd14;
    localparam logic [3:0] NIB_RESERVED = 4'hF;
    localparam logic [16:0] EXT1_BIAS = 17'd13;
    localparam logic [16:0] EXT2_BIAS = 17'd269;
    localparam logic [3:0] TOKEN_MAX = 4'd8;
    localparam logic [11:0] COUNT_SAT = 12'd4095;
    localparam logic [2:0] CLASS_RSVD1 = 3'd1;
    localparam logic [2:0] CLASS_RSVD6 = 3'd6;
    localparam logic [2:0] CLASS_RSVD7 = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } cmv_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  msg_type;
        logic [3:0]  token_length;
        logic [7:0]  code;
        logic [15:0] message_id;
        logic [10:0] payload_offset;
        logic [10:0] payload_length;
    } cmv_out_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       is_marker;
        logic       is_reserved;
    } cmv_cls_t;

    typedef struct packed {
        logic               too_long;
        logic               too_short;
        logic               four_bytes;
        logic [1:0]         first_error;
        logic [PHASE_W-1:0] phase;
        logic [1:0]         msg_type;
        logic [3:0]         token_length;
        logic [7:0]         code;
        logic [15:0]        message_id;
        logic [10:0]        payload_start;
        logic [11:0]        payload_count;
    } cmv_snap_t;

endpackage

// ----- rtl/core/cmv_queue.sv -----
// Small first-in first-out queue with a combinational head read.
// Depends on nothing; used between the front and walk stages and for results.
module cmv_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH_LOG2 = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int DEPTH = 1 << DEPTH_LOG2;
    localparam int CNT_W = DEPTH_LOG2 + 1;

    logic [WIDTH-1:0]      mem [DEPTH];
    logic [DEPTH_LOG2-1:0] wr_ptr_reg;
    logic [DEPTH_LOG2-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + DEPTH_LOG2'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + DEPTH_LOG2'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/core/cmv_front.sv -----
// Input stage: accepts bytes, marks payload markers and reserved nibbles,
// and hands them to the byte queue. Depends on cmv_pkg.
module cmv_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cmv_pkg::cmv_in_t  item,
    output logic              full,
    input  logic              q_full,
    output logic              q_write,
    output cmv_pkg::cmv_cls_t q_item
);

    import cmv_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    cmv_cls_t item_reg;
    logic     accept;

    assign full = valid_reg && q_full;
    assign accept = push && !full;
    assign q_write = valid_reg && !q_full;
    assign q_item = item_reg;
    assign valid_next = accept || (valid_reg && q_full);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data_byte <= item.data_byte;
            item_reg.last_byte <= item.last_byte;
            item_reg.is_marker <= (item.data_byte == MARKER_BYTE);
            item_reg.is_reserved <= (item.data_byte[7:4] == NIB_RESERVED) ||
                                    (item.data_byte[3:0] == NIB_RESERVED);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

// ----- rtl/core/cmv_walk.sv -----
// Parser stage: walks the header, token, options and payload one byte per cycle
// unless stalled, and snapshots the message at its last byte. Depends on cmv_pkg.
module cmv_walk #(
    parameter int MAX_MESSAGE_BYTES = cmv_pkg::DEFAULT_MAX_MESSAGE_BYTES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        max_option_length,
    input  logic               q_empty,
    input  cmv_pkg::cmv_cls_t  q_item,
    output logic               q_read,
    input  logic               snap_ready,
    output logic               snap_valid,
    output cmv_pkg::cmv_snap_t snap
);

    import cmv_pkg::*;

    localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 2);
    localparam int EXT_W = (POS_W > 11) ? POS_W : 11;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [1:0]         type_reg, type_next;
    logic [3:0]         tl_reg, tl_next;
    logic [7:0]         code_reg, code_next;
    logic [15:0]        id_reg, id_next;
    logic [15:0]        left_reg, left_next;
    logic [3:0]         pend_reg, pend_next;
    logic [7:0]         ext_hi_reg, ext_hi_next;
    logic [1:0]         ferr_reg, ferr_next;
    logic [10:0]        pstart_reg, pstart_next;
    logic [11:0]        pcount_reg, pcount_next;
    logic               snap_valid_reg, snap_valid_next;
    cmv_snap_t          snap_reg, snap_next;

    logic [7:0]  b;
    logic        slot_free;
    logic [3:0]  stage_nib;
    logic [16:0] fin_len;
    logic        fin_over;
    logic [10:0] pos_plus_one;
    logic        go_stage;
    logic        go_finish;
    logic        do_flag;

    assign b = q_item.data_byte;
    assign slot_free = !snap_valid_reg || snap_ready;
    assign q_read = !q_empty && (!q_item.last_byte || slot_free);
    assign snap_valid = snap_valid_reg;
    assign snap = snap_reg;

    assign stage_nib = (phase_reg == PH_DELTA_EXT) ? pend_reg : b[3:0];
    assign pos_plus_one = 11'(EXT_W'(pos_reg) + EXT_W'(1));

    always_comb
    begin
        if (phase_reg == PH_LEN_EXT)
        begin
            if (pend_reg == NIB_EXT2)
            begin
                fin_len = 17'({ext_hi_reg, b}) + EXT2_BIAS;
            end
            else
            begin
                fin_len = 17'(b) + EXT1_BIAS;
            end
        end
        else
        begin
            fin_len = 17'(stage_nib);
        end
    end

    assign fin_over = fin_len > {1'b0, max_option_length};

    always_comb
    begin
        pos_next = pos_reg;
        phase_next = phase_reg;
        type_next = type_reg;
        tl_next = tl_reg;
        code_next = code_reg;
        id_next = id_reg;
        left_next = left_reg;
        pend_next = pend_reg;
        ext_hi_next = ext_hi_reg;
        ferr_next = ferr_reg;
        pstart_next = pstart_reg;
        pcount_next = pcount_reg;
        snap_valid_next = snap_valid_reg && !snap_ready;
        snap_next = snap_reg;
        go_stage = 1'b0;
        go_finish = 1'b0;
        do_flag = 1'b0;

        if (q_read)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    if (b[7:6] != VERSION_ONE)
                    begin
                        ferr_next = ERR_VERSION;
                    end
                    type_next = b[5:4];
                    tl_next = b[3:0];
                    phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    code_next = b;
                    phase_next = PH_HDR2;
                end
                PH_HDR2:
                begin
                    id_next = {b, 8'h00};
                    phase_next = PH_HDR3;
                end
                PH_HDR3:
                begin
                    id_next = {id_reg[15:8], b};
                    if (tl_reg == 4'd0)
                    begin
                        phase_next = PH_OPT_FIRST;
                    end
                    else
                    begin
                        left_next = 16'(tl_reg);
                        phase_next = PH_TOKEN;
                    end
                end
                PH_TOKEN:
                begin
                    left_next = left_reg - 16'd1;
                    if (left_reg == 16'd1)
                    begin
                        phase_next = PH_OPT_FIRST;
                    end
                end
                PH_OPT_FIRST, PH_OPT_START:
                begin
                    if (q_item.is_marker)
                    begin
                        if (phase_reg == PH_OPT_FIRST)
                        begin
                            do_flag = 1'b1;
                        end
                        else
                        begin
                            pstart_next = pos_plus_one;
                            pcount_next = '0;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else if (q_item.is_reserved)
                    begin
                        do_flag = 1'b1;
                    end
                    else
                    begin
                        pend_next = b[3:0];
                        if (b[7:4] == NIB_EXT1)
                        begin
                            left_next = 16'd1;
                            phase_next = PH_DELTA_EXT;
                        end
                        else if (b[7:4] == NIB_EXT2)
                        begin
                            left_next = 16'd2;
                            phase_next = PH_DELTA_EXT;
                        end
                        else
                        begin
                            go_stage = 1'b1;
                        end
                    end
                end
                PH_DELTA_EXT:
                begin
                    left_next = left_reg - 16'd1;
                    if (left_reg == 16'd1)
                    begin
                        go_stage = 1'b1;
                    end
                end
                PH_LEN_EXT:
                begin
                    if (pend_reg == NIB_EXT2 && left_reg == 16'd2)
                    begin
                        ext_hi_next = b;
                        left_next = 16'd1;
                    end
                    else
                    begin
                        go_finish = 1'b1;
                    end
                end
                PH_VALUE:
                begin
                    left_next = left_reg - 16'd1;
                    if (left_reg == 16'd1)
                    begin
                        phase_next = PH_OPT_START;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (pcount_reg < COUNT_SAT)
                    begin
                        pcount_next = pcount_reg + 12'd1;
                    end
                end
                default:
                begin
                end
            endcase

            if (go_stage)
            begin
                if (stage_nib == NIB_EXT1)
                begin
                    left_next = 16'd1;
                    phase_next = PH_LEN_EXT;
                end
                else if (stage_nib == NIB_EXT2)
                begin
                    left_next = 16'd2;
                    phase_next = PH_LEN_EXT;
                end
                else
                begin
                    go_finish = 1'b1;
                end
            end

            if (go_finish)
            begin
                if (fin_over)
                begin
                    do_flag = 1'b1;
                end
                else if (fin_len == 17'd0)
                begin
                    phase_next = PH_OPT_START;
                end
                else
                begin
                    left_next = fin_len[15:0];
                    phase_next = PH_VALUE;
                end
            end

            if (do_flag)
            begin
                if (ferr_reg == ERR_OK)
                begin
                    ferr_next = ERR_FORMAT;
                end
                phase_next = PH_SKIP;
            end

            if (pos_reg <= POS_W'(MAX_MESSAGE_BYTES))
            begin
                pos_next = pos_reg + POS_W'(1);
            end

            if (q_item.last_byte)
            begin
                snap_valid_next = 1'b1;
                snap_next.too_long = pos_next > POS_W'(MAX_MESSAGE_BYTES);
                snap_next.too_short = pos_next < POS_W'(4);
                snap_next.four_bytes = pos_next == POS_W'(4);
                snap_next.first_error = ferr_next;
                snap_next.phase = phase_next;
                snap_next.msg_type = type_next;
                snap_next.token_length = tl_next;
                snap_next.code = code_next;
                snap_next.message_id = id_next;
                snap_next.payload_start = pstart_next;
                snap_next.payload_count = pcount_next;

                pos_next = '0;
                phase_next = PH_HDR0;
                type_next = '0;
                tl_next = '0;
                code_next = '0;
                id_next = '0;
                left_next = '0;
                pend_next = '0;
                ext_hi_next = '0;
                ferr_next = ERR_OK;
                pstart_next = '0;
                pcount_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            phase_reg <= PH_HDR0;
            type_reg <= '0;
            tl_reg <= '0;
            code_reg <= '0;
            id_reg <= '0;
            left_reg <= '0;
            pend_reg <= '0;
            ext_hi_reg <= '0;
            ferr_reg <= ERR_OK;
            pstart_reg <= '0;
            pcount_reg <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            phase_reg <= phase_next;
            type_reg <= type_next;
            tl_reg <= tl_next;
            code_reg <= code_next;
            id_reg <= id_next;
            left_reg <= left_next;
            pend_reg <= pend_next;
            ext_hi_reg <= ext_hi_next;
            ferr_reg <= ferr_next;
            pstart_reg <= pstart_next;
            pcount_reg <= pcount_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid_reg && !snap_ready |=> snap_valid_reg && $stable(snap_reg))
        else $error("Pending snapshot changed while the verdict stage was stalled.");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_read && q_item.last_byte |=> phase_reg == PH_HDR0 && pos_reg == '0)
        else $error("Parser state was not cleared after the last byte.");

    a_skip_has_error: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> ferr_reg != ERR_OK)
        else $error("Parser is skipping bytes without a recorded error.");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_MESSAGE_BYTES + 1))
        else $error("Byte position ran past its saturation value.");

endmodule

// ----- rtl/core/cmv_verdict.sv -----
// Verdict stage: turns a message snapshot into the final status and result
// item and writes it to the result queue. Depends on cmv_pkg.
module cmv_verdict (
    input  logic               snap_valid,
    input  cmv_pkg::cmv_snap_t snap,
    input  logic [10:0]        max_payload_length,
    output logic               snap_ready,
    input  logic               out_full,
    output logic               out_write,
    output cmv_pkg::cmv_out_t  out_result
);

    import cmv_pkg::*;

    logic [2:0] code_class;
    logic [1:0] status;

    assign snap_ready = !out_full;
    assign out_write = snap_valid && !out_full;
    assign code_class = snap.code[7:5];

    always_comb
    begin
        status = ERR_OK;
        if (snap.too_long || snap.too_short)
        begin
            status = ERR_FORMAT;
        end
        else if (snap.first_error == ERR_VERSION)
        begin
            status = ERR_VERSION;
        end
        else if (snap.token_length > TOKEN_MAX)
        begin
            status = ERR_FORMAT;
        end
        else if (snap.code == 8'd0 && (!snap.four_bytes || snap.token_length != 4'd0))
        begin
            status = ERR_FORMAT;
        end
        else if (code_class == CLASS_RSVD1 || code_class == CLASS_RSVD6 ||
                 code_class == CLASS_RSVD7)
        begin
            status = ERR_FORMAT;
        end
        else if (snap.phase == PH_TOKEN || snap.first_error != ERR_OK)
        begin
            status = ERR_FORMAT;
        end
        else if (snap.phase == PH_DELTA_EXT || snap.phase == PH_LEN_EXT ||
                 snap.phase == PH_VALUE)
        begin
            status = ERR_FORMAT;
        end
        else if (snap.phase == PH_PAYLOAD)
        begin
            if (snap.payload_count == 12'd0)
            begin
                status = ERR_FORMAT;
            end
            else if (snap.payload_count > {1'b0, max_payload_length})
            begin
                status = ERR_PAYLOAD;
            end
        end
    end

    always_comb
    begin
        out_result.status = status;
        out_result.msg_type = snap.msg_type;
        out_result.token_length = snap.token_length;
        out_result.code = snap.code;
        out_result.message_id = snap.message_id;
        if (status == ERR_OK && snap.phase == PH_PAYLOAD)
        begin
            out_result.payload_offset = snap.payload_start;
            out_result.payload_length = snap.payload_count[10:0];
        end
        else
        begin
            out_result.payload_offset = '0;
            out_result.payload_length = '0;
        end
    end

endmodule

// ----- rtl/core/coap_message_validator.sv -----
// Top level of the CoAP message validator: configuration registers, the
// front, walk and verdict stages, and the two queues. Depends on cmv_pkg.
//
// The block takes one message byte per cycle while full is low, and gives
// one result item for each byte flagged as the last of its message. The single
// parser state update per byte in the walk stage sets that rate. A last byte
// goes via the front register, byte queue and snapshot register to the result
// queue. Input bytes queue up behind a stalled result side until the byte
// queue fills, and then full rises. The user must write the two limits on the
// cfg port only while no message is in flight; the block does not enforce it.
module coap_message_validator #(
    parameter int MAX_MESSAGE_BYTES = cmv_pkg::DEFAULT_MAX_MESSAGE_BYTES,
    parameter int IN_QUEUE_LOG2 = cmv_pkg::IN_QUEUE_LOG2,
    parameter int OUT_QUEUE_LOG2 = cmv_pkg::OUT_QUEUE_LOG2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  cmv_pkg::cmv_in_t                item,
    output logic                            full,
    output logic                            empty,
    input  logic                            pop,
    output cmv_pkg::cmv_out_t               result,
    input  logic                            cfg_write,
    input  logic [cmv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cmv_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import cmv_pkg::*;

    logic [15:0] opt_max_reg;
    logic [10:0] pay_max_reg;

    logic      inq_write;
    cmv_cls_t  inq_wdata;
    logic      inq_full;
    logic      inq_read;
    cmv_cls_t  inq_rdata;
    logic      inq_empty;

    logic      snap_valid;
    cmv_snap_t snap;
    logic      snap_ready;

    logic      outq_write;
    cmv_out_t  outq_wdata;
    logic      outq_full;
    logic      outq_read;

    assign outq_read = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opt_max_reg <= MAX_OPTION_RESET;
            pay_max_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAX_OPTION:  opt_max_reg <= cfg_data[15:0];
                REG_MAX_PAYLOAD: pay_max_reg <= cfg_data[10:0];
                default:
                begin
                end
            endcase
        end
    end

    cmv_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .q_full  (inq_full),
        .q_write (inq_write),
        .q_item  (inq_wdata)
    );

    cmv_queue #(
        .WIDTH      ($bits(cmv_cls_t)),
        .DEPTH_LOG2 (IN_QUEUE_LOG2)
    ) u_in_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (inq_write),
        .wr_data (inq_wdata),
        .full    (inq_full),
        .rd_en   (inq_read),
        .rd_data (inq_rdata),
        .empty   (inq_empty)
    );

    cmv_walk #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_walk (
        .clk               (clk),
        .rst_n             (rst_n),
        .max_option_length (opt_max_reg),
        .q_empty           (inq_empty),
        .q_item            (inq_rdata),
        .q_read            (inq_read),
        .snap_ready        (snap_ready),
        .snap_valid        (snap_valid),
        .snap              (snap)
    );

    cmv_verdict u_verdict (
        .snap_valid         (snap_valid),
        .snap               (snap),
        .max_payload_length (pay_max_reg),
        .snap_ready         (snap_ready),
        .out_full           (outq_full),
        .out_write          (outq_write),
        .out_result         (outq_wdata)
    );

    cmv_queue #(
        .WIDTH      ($bits(cmv_out_t)),
        .DEPTH_LOG2 (OUT_QUEUE_LOG2)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (outq_write),
        .wr_data (outq_wdata),
        .full    (outq_full),
        .rd_en   (outq_read),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

// ----- bench/coap_message_validator_tb.sv -----
// Self-checking bench for coap_message_validator: streams CoAP messages one byte per item
// and compares every verdict with an in-bench parser of the same message rules.
// Depends on cmv_pkg and the coap_message_validator RTL.
module coap_message_validator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cmv_pkg::*;

    typedef logic [7:0] octets_t[$];

    localparam int MSG_LIMIT = 64;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    cmv_in_t item = '0;
    logic full;
    logic empty;
    logic pop = 1'b0;
    cmv_out_t result;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cmv_in_t bytes_to_send[$];
    cmv_out_t verdicts_due[$];
    octets_t frame;
    bit calm = 1'b0;
    int mismatches = 0;
    int verdicts_seen = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int rx_hold = 0;
    bit long_hold_done = 1'b0;

    logic [15:0] opt_limit;
    logic [10:0] pay_limit;
    logic [11:0] msg_bytes;
    logic [3:0] walk_state;
    logic [1:0] hdr_type;
    logic [3:0] hdr_tkl;
    logic [7:0] hdr_code;
    logic [15:0] hdr_id;
    logic [16:0] field_left;
    logic [3:0] len_nibble;
    logic [7:0] ext_high;
    logic [1:0] walk_error;
    logic [11:0] body_start;
    logic [11:0] body_count;

    coap_message_validator #(
        .MAX_MESSAGE_BYTES(MSG_LIMIT)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .item(item),
        .full(full),
        .empty(empty),
        .pop(pop),
        .result(result),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("coap_message_validator_tb failed");
        $finish;
    end

    function automatic void clear_walk();
        msg_bytes = '0;
        walk_state = PH_HDR0;
        hdr_type = '0;
        hdr_tkl = '0;
        hdr_code = '0;
        hdr_id = '0;
        field_left = '0;
        len_nibble = '0;
        ext_high = '0;
        walk_error = ERR_OK;
        body_start = '0;
        body_count = '0;
    endfunction

    function automatic void raise_format();
        if (walk_error == ERR_OK)
        begin
            walk_error = ERR_FORMAT;
        end
        walk_state = PH_SKIP;
    endfunction

    function automatic void close_length(logic [16:0] len);
        if (len > {1'b0, opt_limit})
        begin
            raise_format();
        end
        else if (len == 0)
        begin
            walk_state = PH_OPT_START;
        end
        else
        begin
            field_left = len;
            walk_state = PH_VALUE;
        end
    endfunction

    function automatic void after_delta();
        if (len_nibble == NIB_EXT1)
        begin
            field_left = 17'd1;
            walk_state = PH_LEN_EXT;
        end
        else if (len_nibble == NIB_EXT2)
        begin
            field_left = 17'd2;
            walk_state = PH_LEN_EXT;
        end
        else
        begin
            close_length({13'd0, len_nibble});
        end
    endfunction

    function automatic void option_head(logic [7:0] b, bit opening);
        if (b == MARKER_BYTE)
        begin
            if (opening)
            begin
                raise_format();
            end
            else
            begin
                body_start = msg_bytes + 12'd1;
                body_count = '0;
                walk_state = PH_PAYLOAD;
            end
        end
        else if (b[7:4] == NIB_RESERVED || b[3:0] == NIB_RESERVED)
        begin
            raise_format();
        end
        else
        begin
            len_nibble = b[3:0];
            if (b[7:4] == NIB_EXT1)
            begin
                field_left = 17'd1;
                walk_state = PH_DELTA_EXT;
            end
            else if (b[7:4] == NIB_EXT2)
            begin
                field_left = 17'd2;
                walk_state = PH_DELTA_EXT;
            end
            else
            begin
                after_delta();
            end
        end
    endfunction

    function automatic void walk_byte(logic [7:0] b);
        case (walk_state)
            PH_HDR0:
            begin
                if (b[7:6] != VERSION_ONE)
                begin
                    walk_error = ERR_VERSION;
                end
                hdr_type = b[5:4];
                hdr_tkl = b[3:0];
                walk_state = PH_HDR1;
            end
            PH_HDR1:
            begin
                hdr_code = b;
                walk_state = PH_HDR2;
            end
            PH_HDR2:
            begin
                hdr_id = {b, 8'h00};
                walk_state = PH_HDR3;
            end
            PH_HDR3:
            begin
                hdr_id[7:0] = b;
                if (hdr_tkl == 0)
                begin
                    walk_state = PH_OPT_FIRST;
                end
                else
                begin
                    field_left = {13'd0, hdr_tkl};
                    walk_state = PH_TOKEN;
                end
            end
            PH_TOKEN:
            begin
                field_left = field_left - 17'd1;
                if (field_left == 0)
                begin
                    walk_state = PH_OPT_FIRST;
                end
            end
            PH_OPT_FIRST:
            begin
                option_head(b, 1'b1);
            end
            PH_OPT_START:
            begin
                option_head(b, 1'b0);
            end
            PH_DELTA_EXT:
            begin
                field_left = field_left - 17'd1;
                if (field_left == 0)
                begin
                    after_delta();
                end
            end
            PH_LEN_EXT:
            begin
                if (len_nibble == NIB_EXT2 && field_left == 17'd2)
                begin
                    ext_high = b;
                    field_left = 17'd1;
                end
                else if (len_nibble == NIB_EXT2)
                begin
                    close_length({1'b0, ext_high, b} + EXT2_BIAS);
                end
                else
                begin
                    close_length({9'd0, b} + EXT1_BIAS);
                end
            end
            PH_VALUE:
            begin
                field_left = field_left - 17'd1;
                if (field_left == 0)
                begin
                    walk_state = PH_OPT_START;
                end
            end
            PH_PAYLOAD:
            begin
                if (body_count < COUNT_SAT)
                begin
                    body_count = body_count + 12'd1;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [1:0] verdict_for(logic [11:0] n);
        logic [2:0] cls;
        cls = hdr_code[7:5];
        if (n > MSG_LIMIT) return ERR_FORMAT;
        if (n < 4) return ERR_FORMAT;
        if (walk_error == ERR_VERSION) return ERR_VERSION;
        if (hdr_tkl > TOKEN_MAX) return ERR_FORMAT;
        if (hdr_code == 8'h00 && (n != 4 || hdr_tkl != 0)) return ERR_FORMAT;
        if (cls == CLASS_RSVD1 || cls == CLASS_RSVD6 || cls == CLASS_RSVD7) return ERR_FORMAT;
        if (walk_state == PH_TOKEN) return ERR_FORMAT;
        if (walk_error != ERR_OK) return ERR_FORMAT;
        if (walk_state == PH_DELTA_EXT || walk_state == PH_LEN_EXT || walk_state == PH_VALUE)
            return ERR_FORMAT;
        if (walk_state == PH_PAYLOAD && body_count == 0) return ERR_FORMAT;
        if (walk_state == PH_PAYLOAD && body_count > pay_limit) return ERR_PAYLOAD;
        return ERR_OK;
    endfunction

    function automatic void absorb_byte(cmv_in_t b);
        cmv_out_t v;
        walk_byte(b.data_byte);
        if (msg_bytes <= MSG_LIMIT)
        begin
            msg_bytes = msg_bytes + 12'd1;
        end
        if (b.last_byte)
        begin
            v = '0;
            v.status = verdict_for(msg_bytes);
            v.msg_type = hdr_type;
            v.token_length = hdr_tkl;
            v.code = hdr_code;
            v.message_id = hdr_id;
            if (v.status == ERR_OK && walk_state == PH_PAYLOAD)
            begin
                v.payload_offset = body_start[10:0];
                v.payload_length = body_count[10:0];
            end
            verdicts_due.push_back(v);
            clear_walk();
        end
    endfunction

    function automatic void check_verdict(cmv_out_t got);
        cmv_out_t want;
        verdicts_seen++;
        if (verdicts_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("verdict %0d arrived with none expected: got %p", verdicts_seen, got);
            end
            return;
        end
        want = verdicts_due.pop_front();
        if (got.status !== want.status || got.msg_type !== want.msg_type
            || got.token_length !== want.token_length || got.code !== want.code
            || got.message_id !== want.message_id
            || got.payload_offset !== want.payload_offset
            || got.payload_length !== want.payload_length)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("verdict %0d mismatch: expected %p, got %p", verdicts_seen, want, got);
            end
        end
    endfunction

    task automatic set_limits(logic [15:0] opt_value, logic [15:0] pay_value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_MAX_OPTION;
        cfg_data <= opt_value;
        @(posedge clk);
        cfg_index <= REG_MAX_PAYLOAD;
        cfg_data <= pay_value;
        @(posedge clk);
        cfg_write <= 1'b0;
        opt_limit = opt_value;
        pay_limit = pay_value[10:0];
    endtask

    task automatic drain();
        while (bytes_to_send.size() != 0 || verdicts_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic open_frame(logic [7:0] b0, logic [7:0] code, logic [15:0] id);
        frame.delete();
        frame.push_back(b0);
        frame.push_back(code);
        frame.push_back(id[15:8]);
        frame.push_back(id[7:0]);
    endtask

    task automatic add_bytes(octets_t tail);
        foreach (tail[i])
        begin
            frame.push_back(tail[i]);
        end
    endtask

    task automatic add_random(int count);
        for (int i = 0; i < count; i++)
        begin
            frame.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic ship_frame();
        cmv_in_t x;
        for (int i = 0; i < frame.size(); i++)
        begin
            x.data_byte = frame[i];
            x.last_byte = (i == frame.size() - 1);
            bytes_to_send.push_back(x);
        end
        frame.delete();
    endtask

    task automatic add_option();
        logic [3:0] dn;
        logic [3:0] ln;
        int pick;
        int vlen;
        dn = 4'($urandom_range(0, 14));
        pick = $urandom_range(0, 9);
        if (pick < 7)
            vlen = $urandom_range(0, 12);
        else if (pick < 9)
            vlen = $urandom_range(13, 40);
        else
            vlen = 269 + $urandom_range(0, 65535);
        if (vlen < 13)
            ln = 4'(vlen);
        else if (vlen < 269)
            ln = NIB_EXT1;
        else
            ln = NIB_EXT2;
        frame.push_back({dn, ln});
        if (dn == NIB_EXT1)
            add_random(1);
        else if (dn == NIB_EXT2)
            add_random(2);
        if (vlen >= 269)
        begin
            frame.push_back(8'((vlen - 269) >> 8));
            frame.push_back(8'(vlen - 269));
            add_random($urandom_range(0, 3));
        end
        else
        begin
            if (vlen >= 13)
                frame.push_back(8'(vlen - 13));
            add_random(vlen);
        end
    endtask

    task automatic build_random_message();
        int kind;
        int cut;
        logic [2:0] cls;
        logic [3:0] tkl;
        logic [7:0] code;
        kind = $urandom_range(0, 19);
        frame.delete();
        if (kind < 2)
        begin
            add_random($urandom_range(1, 10));
            return;
        end
        if (kind == 2)
        begin
            open_frame({VERSION_ONE, 2'($urandom_range(0, 3)), 4'd0}, 8'h00, 16'($urandom));
            return;
        end
        tkl = 4'($urandom_range(0, 8));
        case ($urandom_range(0, 4))
            0: cls = 3'd0;
            1: cls = 3'd2;
            2: cls = 3'd3;
            3: cls = 3'd4;
            default: cls = 3'd5;
        endcase
        code = {cls, 5'($urandom_range(0, 31))};
        if (code == 8'h00)
            code = 8'h01;
        open_frame({VERSION_ONE, 2'($urandom_range(0, 3)), tkl}, code, 16'($urandom));
        add_random(tkl);
        repeat ($urandom_range(0, 3)) add_option();
        if ($urandom_range(0, 1) == 1)
        begin
            frame.push_back(MARKER_BYTE);
            add_random($urandom_range(1, pay_limit < 16 ? pay_limit + 2 : 16));
        end
        if (kind < 6)
        begin
            cut = $urandom_range(1, frame.size());
            while (frame.size() > cut)
                void'(frame.pop_back());
        end
        else if (kind == 6)
        begin
            frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endtask

    task automatic random_traffic(int budget);
        int queued;
        int messages;
        queued = 0;
        messages = 0;
        while (queued < budget || messages < 1)
        begin
            build_random_message();
            queued += frame.size();
            messages++;
            ship_frame();
        end
    endtask

    // Sender: the item on the port stays put while full holds it back.
    always @(posedge clk)
    begin : drive
        bit offer;
        if (rst_n)
        begin
            if (push && !full)
            begin
                absorb_byte(item);
                void'(bytes_to_send.pop_front());
            end
            if (push && full)
            begin
                offer = 1'b1;
            end
            else if (tx_gap != 0)
            begin
                tx_gap--;
                offer = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                tx_gap = $urandom_range(0, 6);
                offer = 1'b0;
            end
            else
            begin
                offer = (bytes_to_send.size() != 0);
            end
            push <= offer;
            if (offer)
            begin
                item <= bytes_to_send[0];
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold != 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else if (!long_hold_done && bytes_to_send.size() > 100)
            begin
                long_hold_done = 1'b1;
                rx_hold = 400;
                pop <= 1'b0;
            end
            else if (rx_gap != 0)
            begin
                rx_gap--;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                rx_gap = $urandom_range(0, 6);
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            check_verdict(result);
        end
    end

    initial
    begin
        opt_limit = MAX_OPTION_RESET;
        pay_limit = MAX_PAYLOAD_RESET;
        clear_walk();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header checks, option walk and payload rules under the reset limits.
        frame.delete();
        add_bytes('{8'h40});
        ship_frame();
        frame.delete();
        add_bytes('{8'h5A, 8'h45, 8'h12});
        ship_frame();
        open_frame(8'h40, 8'h00, 16'h1234);
        ship_frame();
        open_frame(8'h40, 8'h00, 16'h0001);
        add_bytes('{8'h00});
        ship_frame();
        open_frame(8'h41, 8'h00, 16'h0001);
        add_bytes('{8'hAA});
        ship_frame();
        open_frame(8'h00, 8'h01, 16'h0000);
        ship_frame();
        open_frame(8'hF8, 8'hFF, 16'hFFFF);
        ship_frame();
        open_frame(8'h79, 8'h01, 16'hABCD);
        add_random(9);
        ship_frame();
        open_frame(8'h40, 8'h20, 16'h0002);
        ship_frame();
        open_frame(8'h40, 8'hC0, 16'h0003);
        ship_frame();
        open_frame(8'h40, 8'hFF, 16'h0004);
        ship_frame();
        open_frame(8'h48, 8'h01, 16'h0005);
        add_random(3);
        ship_frame();
        open_frame(8'h68, 8'h45, 16'hFFFF);
        add_random(8);
        ship_frame();
        open_frame(8'h41, 8'h01, 16'h0006);
        add_bytes('{8'hAA, MARKER_BYTE, 8'h01});
        ship_frame();
        open_frame(8'h40, 8'h02, 16'h0007);
        add_bytes('{8'hF1, 8'h00});
        ship_frame();
        open_frame(8'h70, 8'h84, 16'h0008);
        add_bytes('{8'h1F});
        ship_frame();
        open_frame(8'h40, 8'h03, 16'h0009);
        add_bytes('{8'hD1, 8'h20, 8'hAB, MARKER_BYTE, 8'h01});
        ship_frame();
        open_frame(8'h40, 8'h60, 16'h000A);
        add_bytes('{8'hED, 8'h01, 8'h02, 8'h00});
        add_random(13);
        ship_frame();
        open_frame(8'h40, 8'hA0, 16'h000B);
        add_bytes('{8'h1E, 8'h03, 8'h00});
        ship_frame();
        open_frame(8'h40, 8'h01, 16'h000C);
        add_bytes('{8'h1E, 8'h00, 8'h00});
        add_random(12);
        add_bytes('{MARKER_BYTE, 8'h01, 8'h02});
        ship_frame();
        open_frame(8'h40, 8'h01, 16'h000D);
        add_bytes('{8'hE0, 8'h01});
        ship_frame();
        open_frame(8'h40, 8'h01, 16'h000E);
        add_bytes('{8'h13, 8'hAA});
        ship_frame();
        open_frame(8'h40, 8'h01, 16'h000F);
        add_bytes('{8'h00, MARKER_BYTE});
        ship_frame();
        open_frame(8'h42, 8'h01, 16'h1234);
        add_bytes('{8'hAA, 8'hBB, 8'h00, 8'h11, 8'hCC, MARKER_BYTE, 8'h55, 8'h66, 8'h77});
        ship_frame();
        open_frame(8'h40, 8'h01, 16'h0010);
        add_bytes('{8'hE0, 8'hFF, 8'hFF, 8'h02, 8'hFF, 8'hFF});
        ship_frame();
        open_frame(8'h40, 8'h01, 16'h0011);
        add_bytes('{8'hF0, MARKER_BYTE, MARKER_BYTE, 8'h12});
        ship_frame();
        random_traffic(10);
        drain();

        set_limits(16'h0000, 16'h0000);
        open_frame(8'h40, 8'h01, 16'h0101);
        add_bytes('{8'h00, MARKER_BYTE, 8'h01});
        ship_frame();
        open_frame(8'h40, 8'h01, 16'h0102);
        add_bytes('{8'h01, 8'hAA});
        ship_frame();
        random_traffic(10);
        drain();

        set_limits(16'hFFFF, 16'hFFFF);
        open_frame(8'h40, 8'h02, 16'hBEEF);
        frame.push_back(MARKER_BYTE);
        add_random(MSG_LIMIT + 12);
        ship_frame();
        open_frame(8'h50, 8'h45, 16'h7FFF);
        frame.push_back(MARKER_BYTE);
        add_random(MSG_LIMIT - 5);
        ship_frame();
        open_frame(8'h40, 8'h01, 16'h0201);
        add_bytes('{8'h1E, 8'hFE, 8'hF2});
        ship_frame();
        open_frame(8'h40, 8'h01, 16'h0202);
        add_bytes('{8'h1E, 8'hFE, 8'hF3});
        ship_frame();
        random_traffic(10);
        drain();

        set_limits(16'd5, 16'hF804);
        open_frame(8'h40, 8'h01, 16'h0301);
        add_bytes('{MARKER_BYTE, 8'h01, 8'h02, 8'h03, 8'h04});
        ship_frame();
        open_frame(8'h40, 8'h01, 16'h0302);
        add_bytes('{MARKER_BYTE, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05});
        ship_frame();
        open_frame(8'h40, 8'h01, 16'h0303);
        frame.push_back(8'h05);
        add_random(5);
        ship_frame();
        open_frame(8'h40, 8'h01, 16'h0304);
        frame.push_back(8'h06);
        add_random(6);
        ship_frame();
        random_traffic(10);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            set_limits(16'($urandom_range(0, 40)), 16'($urandom_range(0, 16)));
            if (p == 2)
                calm = 1'b1;
            random_traffic(30);
            drain();
        end

        if (mismatches == 0 && verdicts_due.size() == 0)
        begin
            $display("coap_message_validator_tb passed");
        end
        else
        begin
            $display("coap_message_validator_tb failed");
        end
        $finish;
    end

endmodule

// ----- coap_message_validator.f -----
rtl/core/cmv_pkg.sv
rtl/core/cmv_queue.sv
rtl/core/cmv_front.sv
rtl/core/cmv_walk.sv
rtl/core/cmv_verdict.sv
rtl/core/coap_message_validator.sv
bench/coap_message_validator_tb.sv
